// ===== sv/per_channel_fragment_reassembly_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for per_channel_fragment_reassembly
// Shorthand for clocked implications with the usual reset qualification.
// ----------------------------------------------------------------------------
`ifndef PER_CHANNEL_FRAGMENT_REASSEMBLY_MACROS_SVH
`define PER_CHANNEL_FRAGMENT_REASSEMBLY_MACROS_SVH

// Same-cycle implication.
`define PFR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define PFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/pfr_pkg.sv =====
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared types and constants of the fragment reassembly block.
// ----------------------------------------------------------------------------
package pfr_pkg;

  localparam int CHANNELS_DEF       = 16;
  localparam int MAX_FRAGMENTS_DEF  = 16;
  localparam int FRAGMENT_BYTES_DEF = 64;
  localparam int PAYLOAD_BYTES_DEF  = 1024;

  // Fixed field widths of the ports.
  localparam int CH_W    = 4;
  localparam int SEQ_W   = 32;
  localparam int CNT_W   = 5;
  localparam int FN_W    = 4;
  localparam int TOT_W   = 11;
  localparam int FLEN_W  = 7;
  localparam int BI_W    = 10;
  localparam int BYTE_W  = 8;
  // Running payload offset and its sums.
  localparam int OFF_W   = 12;
  localparam int SUM_W   = 14;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_SLOT,
    ST_LEN,
    ST_FETCH,
    ST_STORE,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic latch;
    logic decode;
    logic rd_finish;
    logic slot_eval;
    logic len_eval;
    logic fetch;
    logic store;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_read;
    logic in_range;
    logic completes;
    logic slot_end;
    logic slot_present;
    logic len_ok;
    logic last_byte;
  } dp_stat_t;

endpackage

// ===== sv/pfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfr_ctrl
// Sequencer for item decode, payload reads and the payload assembly walk.
// ----------------------------------------------------------------------------
module pfr_ctrl import pfr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd,
  output logic      busy
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        if (!stat.in_range) begin
          state_nxt = ST_IDLE;
        end else if (stat.is_read) begin
          state_nxt = ST_READ;
        end else if (stat.completes) begin
          state_nxt = ST_SLOT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        cmd.rd_finish = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_SLOT: begin
        if (stat.slot_end) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.slot_eval = 1'b1;
          if (stat.slot_present) begin
            state_nxt = ST_LEN;
          end
        end
      end
      ST_LEN: begin
        cmd.len_eval = 1'b1;
        state_nxt    = stat.len_ok ? ST_FETCH : ST_SLOT;
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_STORE;
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        state_nxt = stat.last_byte ? ST_SLOT : ST_FETCH;
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== sv/pfr_dp.sv =====
// ----------------------------------------------------------------------------
// pfr_dp
// Per-channel state, fragment and payload memories, and the result register.
// ----------------------------------------------------------------------------
module pfr_dp import pfr_pkg::*; #(
  parameter int CHANNELS       = CHANNELS_DEF,
  parameter int MAX_FRAGMENTS  = MAX_FRAGMENTS_DEF,
  parameter int FRAGMENT_BYTES = FRAGMENT_BYTES_DEF,
  parameter int PAYLOAD_BYTES  = PAYLOAD_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ctrl_cmd_t         cmd,
  output dp_stat_t          stat,
  input  logic              in_req_type,
  input  logic [CH_W-1:0]   in_channel,
  input  logic [SEQ_W-1:0]  in_seq,
  input  logic [CNT_W-1:0]  in_frag_count,
  input  logic [FN_W-1:0]   in_frag_num,
  input  logic [TOT_W-1:0]  in_total_len,
  input  logic [FLEN_W-1:0] in_frag_len,
  input  logic [BI_W-1:0]   in_byte_index,
  input  logic [BYTE_W-1:0] in_data_byte,
  output logic              out_valid,
  output logic              out_complete,
  output logic [TOT_W-1:0]  out_payload_len,
  output logic [BYTE_W-1:0] out_read_byte
);

  localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SLW   = $clog2(MAX_FRAGMENTS + 1);
  localparam int SIW   = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
  localparam int FLW   = $clog2(FRAGMENT_BYTES + 1);
  localparam int PLW   = $clog2(PAYLOAD_BYTES + 1);
  localparam int FB_D  = CHANNELS * MAX_FRAGMENTS * FRAGMENT_BYTES;
  localparam int FL_D  = CHANNELS * MAX_FRAGMENTS;
  localparam int PB_D  = CHANNELS * PAYLOAD_BYTES;
  localparam int FBA_W = (FB_D > 1) ? $clog2(FB_D) : 1;
  localparam int FLA_W = (FL_D > 1) ? $clog2(FL_D) : 1;
  localparam int PBA_W = (PB_D > 1) ? $clog2(PB_D) : 1;

  // Latched item.
  logic              req_r;
  logic [CHW-1:0]    ch_r;
  logic              range_r;
  logic [SEQ_W-1:0]  seq_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [FN_W-1:0]   fn_r;
  logic [TOT_W-1:0]  tot_r;
  logic [FLEN_W-1:0] flen_r;
  logic [BI_W-1:0]   bi_r;
  logic [BYTE_W-1:0] db_r;

  // Per-channel state in flops.
  logic [SEQ_W-1:0]         seq_q     [CHANNELS];
  logic [MAX_FRAGMENTS-1:0] present_r [CHANNELS];
  logic [PLW-1:0]           plen_r    [CHANNELS];
  logic [OFF_W-1:0]         fill_r    [CHANNELS];

  // Memories.
  logic [BYTE_W-1:0] frag_mem [FB_D];
  logic [FLW-1:0]    flen_mem [FL_D];
  logic [BYTE_W-1:0] pay_mem  [PB_D];
  logic [BYTE_W-1:0] frag_q;
  logic [FLW-1:0]    len_q;
  logic [BYTE_W-1:0] pay_q;

  // Assembly walk.
  logic [SLW-1:0]   slot_r;
  logic [OFF_W-1:0] off_r;
  logic [FLW-1:0]   k_r;

  // Result register.
  logic              valid_r;
  logic              complete_r;
  logic [TOT_W-1:0]  plen_out_r;
  logic [BYTE_W-1:0] byte_out_r;
  logic              rd_ok_r;

  logic                     fn_ok, active, last, seq_diff, frag_wr;
  logic [MAX_FRAGMENTS-1:0] frag_bit, pres0, pres1;
  logic [PLW-1:0]           plen_calc;
  logic [SUM_W-1:0]         end_sum, pos_sum;
  logic                     pay_wr;
  logic [FBA_W-1:0]         fb_wr_addr, fb_rd_addr;
  logic [FLA_W-1:0]         fl_wr_addr, fl_rd_addr;
  logic [PBA_W-1:0]         pb_wr_addr, pb_rd_addr;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r   <= in_req_type;
      ch_r    <= CHW'(in_channel);
      range_r <= (32'(in_channel) < CHANNELS);
      seq_r   <= in_seq;
      cnt_r   <= in_frag_count;
      fn_r    <= in_frag_num;
      tot_r   <= in_total_len;
      flen_r  <= in_frag_len;
      bi_r    <= in_byte_index;
      db_r    <= in_data_byte;
    end
  end

  assign fn_ok    = (32'(fn_r) < MAX_FRAGMENTS);
  assign frag_bit = MAX_FRAGMENTS'(1) << fn_r;
  assign seq_diff = (seq_r != seq_q[ch_r]);
  assign pres0    = seq_diff ? '0 : present_r[ch_r];
  assign active   = fn_ok && ((flen_r == '0) || ({1'b0, bi_r} < {4'd0, flen_r}));
  assign last     = (flen_r == '0) || ({4'd0, flen_r} == ({1'b0, bi_r} + 11'd1));

  always_comb begin
    pres1 = pres0;
    if (active) begin
      pres1 = last ? (pres0 | frag_bit) : (pres0 & ~frag_bit);
    end
  end

  assign frag_wr   = cmd.decode && range_r && (req_r == REQ_WRITE);
  assign plen_calc = (32'(tot_r) < PAYLOAD_BYTES) ? PLW'(tot_r) : PLW'(PAYLOAD_BYTES);
  assign end_sum   = SUM_W'(off_r) + SUM_W'(len_q);
  assign pos_sum   = SUM_W'(off_r) + SUM_W'(k_r);
  assign pay_wr    = cmd.store && (32'(pos_sum) < 32'(plen_calc));

  assign fb_wr_addr = FBA_W'((32'(ch_r) * MAX_FRAGMENTS + 32'(fn_r)) * FRAGMENT_BYTES
                             + 32'(bi_r));
  assign fb_rd_addr = FBA_W'((32'(ch_r) * MAX_FRAGMENTS + 32'(slot_r)) * FRAGMENT_BYTES
                             + 32'(k_r));
  assign fl_wr_addr = FLA_W'(32'(ch_r) * MAX_FRAGMENTS + 32'(fn_r));
  assign fl_rd_addr = FLA_W'(32'(ch_r) * MAX_FRAGMENTS + 32'(slot_r));
  assign pb_wr_addr = PBA_W'(32'(ch_r) * PAYLOAD_BYTES + 32'(pos_sum));
  assign pb_rd_addr = PBA_W'(32'(ch_r) * PAYLOAD_BYTES + 32'(bi_r));

  // Fragment byte memory.
  always_ff @(posedge clk) begin
    if (frag_wr && active && (flen_r != '0) && (32'(bi_r) < FRAGMENT_BYTES)) begin
      frag_mem[fb_wr_addr] <= db_r;
    end
    if (cmd.fetch) begin
      frag_q <= frag_mem[fb_rd_addr];
    end
  end

  // Fragment length memory, saturated at the slot size.
  always_ff @(posedge clk) begin
    if (frag_wr && active && last) begin
      flen_mem[fl_wr_addr] <= (32'(flen_r) < FRAGMENT_BYTES) ? FLW'(flen_r)
                                                            : FLW'(FRAGMENT_BYTES);
    end
    if (cmd.slot_eval) begin
      len_q <= flen_mem[fl_rd_addr];
    end
  end

  // Payload memory.
  always_ff @(posedge clk) begin
    if (pay_wr) begin
      pay_mem[pb_wr_addr] <= frag_q;
    end
    if (cmd.decode) begin
      pay_q <= pay_mem[pb_rd_addr];
    end
  end

  // Per-channel control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        seq_q[c]     <= '0;
        present_r[c] <= '0;
        plen_r[c]    <= '0;
        fill_r[c]    <= '0;
      end
    end else begin
      if (frag_wr) begin
        seq_q[ch_r]     <= seq_r;
        present_r[ch_r] <= pres1;
      end
      if (cmd.finish) begin
        present_r[ch_r] <= '0;
        plen_r[ch_r]    <= plen_calc;
        fill_r[ch_r]    <= off_r;
      end
    end
  end

  // Assembly walk counters.
  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      slot_r <= '0;
      off_r  <= '0;
    end
    if (cmd.slot_eval && !present_r[ch_r][SIW'(slot_r)]) begin
      slot_r <= slot_r + SLW'(1);
    end
    if (cmd.len_eval) begin
      k_r <= '0;
      if (!stat.len_ok) begin
        slot_r <= slot_r + SLW'(1);
      end
    end
    if (cmd.store) begin
      k_r <= k_r + FLW'(1);
      if (stat.last_byte) begin
        off_r  <= OFF_W'(end_sum);
        slot_r <= slot_r + SLW'(1);
      end
    end
  end

  assign stat.is_read      = (req_r == REQ_READ);
  assign stat.in_range     = range_r;
  assign stat.completes    = active && last && ($countones(pres1) == 32'(cnt_r));
  assign stat.slot_end     = (32'(slot_r) >= 32'(cnt_r)) || (32'(slot_r) >= MAX_FRAGMENTS);
  assign stat.slot_present = present_r[ch_r][SIW'(slot_r)];
  assign stat.len_ok       = (len_q != '0) && (end_sum <= SUM_W'(tot_r));
  assign stat.last_byte    = ((k_r + FLW'(1)) == len_q);

  // Result register; a result is shown for exactly one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      complete_r <= 1'b0;
    end else begin
      valid_r    <= 1'b0;
      complete_r <= 1'b0;
      if (cmd.decode) begin
        valid_r <= !range_r || ((req_r == REQ_WRITE) && !stat.completes);
      end
      if (cmd.rd_finish) begin
        valid_r <= 1'b1;
      end
      if (cmd.finish) begin
        valid_r    <= 1'b1;
        complete_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      byte_out_r <= '0;
      if (!range_r) begin
        plen_out_r <= '0;
      end else begin
        plen_out_r <= TOT_W'(frag_wr ? (plen_r[ch_r]) : plen_r[ch_r]);
      end
      rd_ok_r <= (32'(bi_r) < 32'(plen_r[ch_r])) && (32'(bi_r) < 32'(fill_r[ch_r]));
    end
    if (cmd.rd_finish) begin
      byte_out_r <= rd_ok_r ? pay_q : '0;
    end
    if (cmd.finish) begin
      plen_out_r <= TOT_W'(plen_calc);
      byte_out_r <= '0;
    end
  end

  assign out_valid       = valid_r;
  assign out_complete    = complete_r;
  assign out_payload_len = plen_out_r;
  assign out_read_byte   = byte_out_r;

endmodule

// ===== sv/per_channel_fragment_reassembly.sv =====
// ----------------------------------------------------------------------------
// per_channel_fragment_reassembly
// Per-channel reassembly of fragmented messages with payload read-back.
// ----------------------------------------------------------------------------
// Usage: an item is taken on a rising edge where start is high and busy is
// low. A write item carries one fragment byte; a read item asks for one byte
// of the channel's assembled payload. Every item gives exactly one result,
// shown on the out_ ports for one cycle while out_valid is high.
// A write that does not finish a message gives its result from the decode
// state, a read from the read-back state after decode. A write that
// finishes a message runs the assembly walk: each stored slot below the
// count is looked up and its length checked, an empty slot is skipped, and
// each copied byte is fetched and stored; a done state gives the result.
// No item is taken before the last one gives its result; the walk steps
// through the single-port fragment and payload memories one byte at a time.
// A new item may be taken in the same cycle its predecessor's result shows.
// Reset clears all sequence numbers, fragment presence and payload lengths;
// the memories need no clearing, since reads past the filled length give 0.
// The receiver cannot stall: it must take each result in its cycle.
// ----------------------------------------------------------------------------
module per_channel_fragment_reassembly import pfr_pkg::*; #(
  parameter int CHANNELS       = CHANNELS_DEF,
  parameter int MAX_FRAGMENTS  = MAX_FRAGMENTS_DEF,
  parameter int FRAGMENT_BYTES = FRAGMENT_BYTES_DEF,
  parameter int PAYLOAD_BYTES  = PAYLOAD_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_req_type,
  input  logic [CH_W-1:0]   in_channel,
  input  logic [SEQ_W-1:0]  in_seq,
  input  logic [CNT_W-1:0]  in_frag_count,
  input  logic [FN_W-1:0]   in_frag_num,
  input  logic [TOT_W-1:0]  in_total_len,
  input  logic [FLEN_W-1:0] in_frag_len,
  input  logic [BI_W-1:0]   in_byte_index,
  input  logic [BYTE_W-1:0] in_data_byte,
  output logic              out_valid,
  output logic              out_complete,
  output logic [TOT_W-1:0]  out_payload_len,
  output logic [BYTE_W-1:0] out_read_byte
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // The controller sequences decode, read-back and the assembly walk.
  pfr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // The datapath holds all channel state, the memories and the result.
  pfr_dp #(
    .CHANNELS       (CHANNELS),
    .MAX_FRAGMENTS  (MAX_FRAGMENTS),
    .FRAGMENT_BYTES (FRAGMENT_BYTES),
    .PAYLOAD_BYTES  (PAYLOAD_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_req_type     (in_req_type),
    .in_channel      (in_channel),
    .in_seq          (in_seq),
    .in_frag_count   (in_frag_count),
    .in_frag_num     (in_frag_num),
    .in_total_len    (in_total_len),
    .in_frag_len     (in_frag_len),
    .in_byte_index   (in_byte_index),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_complete    (out_complete),
    .out_payload_len (out_payload_len),
    .out_read_byte   (out_read_byte)
  );

endmodule

// ===== sv/pfr_checker.sv =====
// ----------------------------------------------------------------------------
// pfr_checker
// Port-level checks of the fragment reassembly block.
// ----------------------------------------------------------------------------
`include "per_channel_fragment_reassembly_macros.svh"

module pfr_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_complete
);

  // An accepted item keeps the block busy in the next cycle.
  `PFR_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // Results never come in back-to-back cycles.
  `PFR_ASSERT_NEXT(a_valid_gap, out_valid, !out_valid)
  // A result appears only once the block is idle again.
  `PFR_ASSERT_NOW(a_valid_idle, out_valid, !busy)
  // Completion is only flagged on a result.
  `PFR_ASSERT_NOW(a_complete_valid, out_complete, out_valid)

endmodule

bind per_channel_fragment_reassembly pfr_checker u_pfr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_complete (out_complete)
);

// ===== verif/per_channel_fragment_reassembly_test.sv =====
// ----------------------------------------------------------------------------
// per_channel_fragment_reassembly_test
// Self-checking testbench for the per-channel fragment reassembly block.
// Fragments are sent as well-formed messages with random content, mixed with
// noise and broken messages. A scoreboard predicts every result, which is
// checked field by field against the block's outputs.
// ----------------------------------------------------------------------------
module per_channel_fragment_reassembly_test;
  import pfr_pkg::*;

  localparam int NCH      = CHANNELS_DEF;
  localparam int NFRAG    = MAX_FRAGMENTS_DEF;
  localparam int FBYTES   = FRAGMENT_BYTES_DEF;
  localparam int PBYTES   = PAYLOAD_BYTES_DEF;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic              req_type;
    logic [CH_W-1:0]   channel;
    logic [SEQ_W-1:0]  seq;
    logic [CNT_W-1:0]  frag_count;
    logic [FN_W-1:0]   frag_num;
    logic [TOT_W-1:0]  total_len;
    logic [FLEN_W-1:0] frag_len;
    logic [BI_W-1:0]   byte_index;
    logic [BYTE_W-1:0] data_byte;
  } frag_item_t;

  typedef struct {
    logic              complete;
    logic [TOT_W-1:0]  payload_len;
    logic [BYTE_W-1:0] read_byte;
  } reasm_result_t;

  // The scoreboard keeps its own copy of every channel's reassembly context
  // and turns each accepted transfer into the result the block must give.
  class reassembly_scoreboard;
    logic [SEQ_W-1:0]  chan_seq [NCH];
    logic [NFRAG-1:0]  present [NCH];
    logic [7:0]        frag_mem [NCH][NFRAG][FBYTES];
    int                frag_size [NCH][NFRAG];
    logic [7:0]        payload [NCH][PBYTES];
    int                payload_size [NCH];
    reasm_result_t     pending [$];
    int                errors;
    int                completions;

    function new();
      for (int c = 0; c < NCH; c++) begin
        chan_seq[c] = '0;
        present[c] = '0;
        payload_size[c] = 0;
        for (int f = 0; f < NFRAG; f++) begin
          frag_size[c][f] = 0;
          for (int b = 0; b < FBYTES; b++) frag_mem[c][f][b] = '0;
        end
        for (int b = 0; b < PBYTES; b++) payload[c][b] = '0;
      end
      errors = 0;
      completions = 0;
    endfunction

    // Concatenates the present slots below the count. A slot whose bytes
    // would run past the total length is skipped over entirely.
    function void assemble(int ch, int cnt, int tot);
      int plen;
      int off;
      int len;
      plen = (tot < PBYTES) ? tot : PBYTES;
      off = 0;
      for (int b = 0; b < PBYTES; b++) payload[ch][b] = '0;
      for (int i = 0; i < cnt && i < NFRAG; i++) begin
        if (present[ch][i]) begin
          len = frag_size[ch][i];
          if (off + len <= tot) begin
            for (int k = 0; k < len; k++)
              if (off + k < plen) payload[ch][off + k] = frag_mem[ch][i][k];
            off += len;
          end
        end
      end
      payload_size[ch] = plen;
      present[ch] = '0;
    endfunction

    function void note_transfer(frag_item_t it);
      reasm_result_t r;
      int ch;
      int fn;
      int flen;
      int bi;
      ch = it.channel;
      fn = it.frag_num;
      flen = it.frag_len;
      bi = it.byte_index;
      r.complete = 1'b0;
      r.read_byte = '0;
      if (it.req_type == REQ_READ) begin
        if (bi < payload_size[ch]) r.read_byte = payload[ch][bi];
      end else begin
        // A new sequence number throws away the partial message.
        if (it.seq != chan_seq[ch]) begin
          chan_seq[ch] = it.seq;
          present[ch] = '0;
        end
        if (flen == 0 || bi < flen) begin
          if (flen != 0 && bi < FBYTES) frag_mem[ch][fn][bi] = it.data_byte;
          if (flen == 0 || bi == flen - 1) begin
            present[ch][fn] = 1'b1;
            frag_size[ch][fn] = (flen < FBYTES) ? flen : FBYTES;
            if ($countones(present[ch]) == int'(it.frag_count)) begin
              assemble(ch, it.frag_count, it.total_len);
              r.complete = 1'b1;
              completions++;
            end
          end else begin
            // The slot is being rewritten, so it no longer counts.
            present[ch][fn] = 1'b0;
          end
        end
      end
      r.payload_len = payload_size[ch][TOT_W-1:0];
      pending.push_back(r);
    endfunction

    function void check_result(logic complete, logic [TOT_W-1:0] plen,
                               logic [BYTE_W-1:0] rbyte);
      reasm_result_t e;
      if (pending.size() == 0) begin
        $error("result with no transfer outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (complete !== e.complete) begin
        $error("complete: expected %0d, actual %0d", e.complete, complete);
        errors++;
      end
      if (plen !== e.payload_len) begin
        $error("payload_len: expected %0d, actual %0d", e.payload_len, plen);
        errors++;
      end
      if (rbyte !== e.read_byte) begin
        $error("read_byte: expected %0d, actual %0d", e.read_byte, rbyte);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_req_type = 1'b0;
  logic [CH_W-1:0]   in_channel = '0;
  logic [SEQ_W-1:0]  in_seq = '0;
  logic [CNT_W-1:0]  in_frag_count = '0;
  logic [FN_W-1:0]   in_frag_num = '0;
  logic [TOT_W-1:0]  in_total_len = '0;
  logic [FLEN_W-1:0] in_frag_len = '0;
  logic [BI_W-1:0]   in_byte_index = '0;
  logic [BYTE_W-1:0] in_data_byte = '0;
  logic              out_valid;
  logic              out_complete;
  logic [TOT_W-1:0]  out_payload_len;
  logic [BYTE_W-1:0] out_read_byte;

  per_channel_fragment_reassembly dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_channel(in_channel), .in_seq(in_seq),
    .in_frag_count(in_frag_count), .in_frag_num(in_frag_num),
    .in_total_len(in_total_len), .in_frag_len(in_frag_len),
    .in_byte_index(in_byte_index), .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_complete(out_complete),
    .out_payload_len(out_payload_len), .out_read_byte(out_read_byte)
  );

  always #2 clk = ~clk;

  reassembly_scoreboard sb = new();

  // Bytes ever written per slot. A fragment is only finished once every one
  // of its stored bytes has been written at some point, so no payload byte
  // ever comes from memory that was never filled.
  logic [FBYTES-1:0] bytes_written [NCH][NFRAG];
  int idle_pct = 0;
  int transfers = 0;
  int reads_sent = 0;
  int stall_cycles = 0;

  // Results are strobed and cannot be held off, so each one is checked in
  // the cycle it shows. The watchdog counts cycles with no transfer at all.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_complete, out_payload_len, out_read_byte);
      if (out_valid || (start && !busy)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("per_channel_fragment_reassembly_test failed");
        $finish;
      end
    end
  end

  // Drives one item at the falling edge and holds it until the block takes
  // it. Start stays high between back-to-back items.
  task automatic drive_item(frag_item_t it);
    int gap;
    int stored;
    logic [FBYTES-1:0] need;
    logic [FBYTES-1:0] have;
    if (it.req_type == REQ_WRITE && (it.frag_len == 0 || it.byte_index < it.frag_len)) begin
      stored = (it.frag_len < FBYTES) ? it.frag_len : FBYTES;
      need = (stored == FBYTES) ? '1 : ((FBYTES'(1) << stored) - 1);
      have = bytes_written[it.channel][it.frag_num];
      if (it.frag_len != 0 && it.byte_index < FBYTES)
        have[it.byte_index] = 1'b1;
      // A last byte that would finish a partly written fragment is moved
      // past the end of the fragment instead, and then writes nothing.
      if ((it.frag_len == 0 || it.byte_index == it.frag_len - 1) &&
          (have & need) != need)
        it.byte_index = it.frag_len;
      else
        bytes_written[it.channel][it.frag_num] = have;
    end
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_req_type <= it.req_type;
    in_channel <= it.channel;
    in_seq <= it.seq;
    in_frag_count <= it.frag_count;
    in_frag_num <= it.frag_num;
    in_total_len <= it.total_len;
    in_frag_len <= it.frag_len;
    in_byte_index <= it.byte_index;
    in_data_byte <= it.data_byte;
    do @(posedge clk); while (busy);
    sb.note_transfer(it);
    transfers++;
    if (it.req_type == REQ_READ) reads_sent++;
  endtask

  task automatic send_write(int ch, logic [31:0] seq, int cnt, int fn, int tot,
                            int flen, int bi, int db);
    frag_item_t it;
    it.req_type = REQ_WRITE;
    it.channel = ch;
    it.seq = seq;
    it.frag_count = cnt;
    it.frag_num = fn;
    it.total_len = tot;
    it.frag_len = flen;
    it.byte_index = bi;
    it.data_byte = db;
    drive_item(it);
  endtask

  task automatic send_read(int ch, int bi);
    frag_item_t it;
    it.req_type = REQ_READ;
    it.channel = ch;
    it.seq = $urandom;
    it.frag_count = $urandom;
    it.frag_num = $urandom;
    it.total_len = $urandom;
    it.frag_len = $urandom;
    it.byte_index = bi;
    it.data_byte = $urandom;
    drive_item(it);
  endtask

  // Sends every byte of one fragment in order.
  task automatic send_fragment(int ch, logic [31:0] seq, int cnt, int fn, int tot,
                               int flen);
    if (flen == 0) send_write(ch, seq, cnt, fn, tot, 0, $urandom_range(1023), $urandom);
    else for (int b = 0; b < flen; b++) send_write(ch, seq, cnt, fn, tot, flen, b, $urandom);
  endtask

  // A well-formed message in shuffled order, now and then with a length
  // that overflows or saturates, a repeated slot, or an early abort.
  task automatic send_message();
    int ch;
    logic [31:0] seq;
    int cnt;
    int tot;
    int lens [NFRAG];
    int order [NFRAG];
    int j;
    int tmp;
    int sent;
    ch = $urandom_range(NCH - 1);
    seq = ($urandom_range(99) < 70) ? $urandom : sb.chan_seq[ch];
    cnt = ($urandom_range(99) < 90) ? $urandom_range(1, 4) : $urandom_range(5, NFRAG);
    tot = 0;
    for (int i = 0; i < cnt; i++) begin
      if (cnt <= 4 && $urandom_range(99) < 8) lens[i] = $urandom_range(0, FBYTES);
      else lens[i] = $urandom_range(0, 6);
      tot += lens[i];
      order[i] = i;
    end
    case ($urandom_range(19))
      0: tot = $urandom_range(0, tot);
      1: tot = $urandom_range(PBYTES - 8, 2047);
      2: tot = tot + $urandom_range(1, 20);
      default: ;
    endcase
    for (int i = cnt - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    sent = ($urandom_range(99) < 10) ? $urandom_range(0, cnt - 1) : cnt;
    for (int i = 0; i < sent; i++) begin
      if ($urandom_range(99) < 5) send_fragment(ch, seq, cnt, order[i], tot, lens[order[i]]);
      send_fragment(ch, seq, cnt, order[i], tot, lens[order[i]]);
    end
    repeat ($urandom_range(0, 3))
      send_read(ch, ($urandom_range(99) < 85) ?
                $urandom_range(0, sb.payload_size[ch] + 1) % 1024 : $urandom_range(1023));
  endtask

  task automatic send_noise();
    frag_item_t it;
    it.req_type = $urandom_range(1);
    it.channel = $urandom;
    it.seq = ($urandom_range(1)) ? $urandom : sb.chan_seq[it.channel];
    it.frag_count = $urandom;
    it.frag_num = $urandom;
    it.total_len = $urandom;
    it.frag_len = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 8);
    it.byte_index = ($urandom_range(1)) ? $urandom : $urandom_range(0, 8);
    it.data_byte = $urandom;
    drive_item(it);
  endtask

  initial begin
    int phase_pct [4] = '{0, 82, 0, 15};
    int target;
    for (int c = 0; c < NCH; c++)
      for (int f = 0; f < NFRAG; f++) bytes_written[c][f] = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: a read after reset, a two-fragment message read back
    // at both ends and beyond, an empty single fragment, a sequence change
    // that drops a partial message, an overflowing fragment, a saturated
    // total length at the field extremes, and counts that never complete.
    send_read(0, 0);
    send_write(1, 32'h5, 2, 1, 5, 2, 0, 8'hff);
    send_write(1, 32'h5, 2, 1, 5, 2, 1, 8'h00);
    send_write(1, 32'h5, 2, 0, 5, 3, 0, 8'h11);
    send_write(1, 32'h5, 2, 0, 5, 3, 1, 8'h22);
    send_write(1, 32'h5, 2, 0, 5, 3, 2, 8'h33);
    send_read(1, 0);
    send_read(1, 4);
    send_read(1, 5);
    send_write(2, 32'h0, 1, 0, 0, 0, 0, 8'haa);
    send_write(3, 32'h7, 2, 0, 4, 1, 0, 8'h01);
    send_write(3, 32'h8, 2, 1, 4, 1, 0, 8'h02);
    send_write(3, 32'h8, 2, 0, 1, 2, 0, 8'h03);
    send_write(3, 32'h8, 2, 0, 1, 2, 1, 8'h04);
    send_write(15, 32'hffffffff, 1, 15, 2047, 1, 0, 8'hff);
    send_write(15, 32'hffffffff, 16, 15, 2047, 1, 0, 8'h80);
    send_read(15, 1023);
    send_write(4, 32'h1, 0, 0, 0, 0, 0, 8'h0);
    send_write(4, 32'h1, 31, 1, 2, 1, 0, 8'h5a);
    send_write(4, 32'h1, 2, 2, 2, 1, 1023, 8'h5a);
    send_read(4, 0);

    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_pct[p];
      target = transfers + 200;
      while (transfers < target) begin
        if ($urandom_range(99) < 80) send_message();
        else send_noise();
      end
    end
    @(negedge clk);
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d transfers (%0d reads), %0d messages completed",
             transfers, reads_sent, sb.completions);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("per_channel_fragment_reassembly_test passed");
    else
      $display("per_channel_fragment_reassembly_test failed");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+sv
sv/pfr_pkg.sv
sv/pfr_ctrl.sv
sv/pfr_dp.sv
sv/per_channel_fragment_reassembly.sv
sv/pfr_checker.sv
verif/per_channel_fragment_reassembly_test.sv
